@@ hw/rtl/arithmetic_symbol_decoder_unit_defines.svh @@
// assertion macros for the arithmetic symbol decoder
// used by arithmetic_symbol_decoder_unit; expects clk and rst in scope
`ifndef ARITHMETIC_SYMBOL_DECODER_UNIT_DEFINES_SVH
`define ARITHMETIC_SYMBOL_DECODER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define ASD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("decoder check failed");
`define ASD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("decoder check failed");
`else
`define ASD_ASSERT_IMP(lbl, ante, cons)
`define ASD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ hw/rtl/asd_pkg.sv @@
// types and constants for the arithmetic symbol decoder
// no dependencies
`timescale 1ns / 1ps
package asd_pkg;
  localparam int MAX_SYMBOLS = 256;
  localparam int CODE_BITS   = 16;
  localparam int WINDOW_BITS = 16;
  localparam int TAB_BITS    = 15;
  localparam int IDX_BITS    = $clog2(MAX_SYMBOLS + 1);
  localparam int SYM_BITS    = $clog2(MAX_SYMBOLS);
  localparam int RNG_BITS    = CODE_BITS + 1;
  localparam int PROD_BITS   = RNG_BITS + TAB_BITS;
  localparam int CNT_BITS    = $clog2(PROD_BITS);
  localparam int USED_BITS   = 5;
  localparam int SC_BITS     = 20;
  localparam logic [SC_BITS-1:0] SC_MAX = '1;
  localparam logic [CODE_BITS-1:0] Q1_POINT   = CODE_BITS'(1) << (CODE_BITS - 2);
  localparam logic [CODE_BITS-1:0] HALF_POINT = CODE_BITS'(1) << (CODE_BITS - 1);
  localparam logic [CODE_BITS-1:0] Q3_POINT   = HALF_POINT + Q1_POINT;
  localparam logic REG_SYMBOL_COUNT = 1'b0;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_START  = 2'd1,
    OP_DECODE = 2'd2,
    OP_FINISH = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_TOT, S_MUL, S_LOAD, S_DIV, S_POST, S_SRD, S_SCMP, S_REN, S_OUT
  } st_t;

  typedef enum logic [1:0] {
    PH_CUM, PH_HI, PH_LO
  } ph_t;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [WINDOW_BITS-1:0]  stream_bits;
    logic [IDX_BITS-1:0]     table_index;
    logic [TAB_BITS-1:0]     table_value;
  } in_beat_t;

  typedef struct packed {
    logic [SYM_BITS-1:0]     symbol;
    logic [USED_BITS-1:0]    bits_consumed;
    logic [SC_BITS-1:0]      total_bits;
  } out_beat_t;
endpackage

@@ hw/rtl/arithmetic_symbol_decoder_unit.sv @@
// arithmetic symbol decoder top level: sequencer, shared multiplier and divider, table memory
// depends on asd_pkg and arithmetic_symbol_decoder_unit_defines.svh
`timescale 1ns / 1ps
`include "arithmetic_symbol_decoder_unit_defines.svh"
//
//  channel   | signals                               | direction
//  ----------+---------------------------------------+----------
//  in        | in_valid, in_stall, in_data           | beat in
//  out       | out_valid, out_stall, out_data        | beat out
//  cfg       | psel penable pwrite paddr pwdata ...  | apb write/read
//
//  load, start and finish write the output register straight from the input beat;
//  decode runs the 32-step restoring divider three times, searches the table
//  downward with one memory read and one compare per entry, and takes 0..16
//  renorm steps; a zero total goes straight from the total read to the output state
//  rst is synchronous; the table memory is not cleared
//  in_stall is high while a decode runs or while a result waits on out_stall
module arithmetic_symbol_decoder_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  asd_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output asd_pkg::out_beat_t  out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  localparam int CB = asd_pkg::CODE_BITS;
  localparam int TB = asd_pkg::TAB_BITS;
  localparam int IB = asd_pkg::IDX_BITS;
  localparam int RB = asd_pkg::RNG_BITS;
  localparam int PB = asd_pkg::PROD_BITS;

  // configuration
  logic [IB-1:0] symbol_count;
  logic [IB-1:0] n_act;

  // session state
  logic [CB-1:0] ilow, ihigh, code;
  logic [asd_pkg::SC_BITS-1:0] sc;

  // sequencer
  asd_pkg::st_t state, state_next;
  asd_pkg::ph_t ph;

  // working registers
  logic [IB-1:0]   n_r, sidx;
  logic [CB-1:0]   win_r;
  logic [TB-1:0]   total_r, prev_r, cs_r, cs1_r;
  logic [RB-1:0]   range_r, cv1_r;
  logic [asd_pkg::SYM_BITS-1:0] sym_r;
  logic [PB-1:0]   prod, quo;
  logic [RB-1:0]   rem, dsr;
  logic [asd_pkg::CNT_BITS-1:0] cnt;
  logic [CB-1:0]   lo_r, hi_r, v_r;
  logic [asd_pkg::USED_BITS-1:0] taken;

  // table memory
  logic [TB-1:0] mem [0:asd_pkg::MAX_SYMBOLS];
  logic [IB-1:0] raddr;
  logic [TB-1:0] rdata;

  // shared unit operands
  logic [RB-1:0] mul_a;
  logic [TB-1:0] mul_b;
  logic [RB:0]   div_r2;
  logic          div_ge;

  // renorm step
  logic          ren_go;
  logic [CB-1:0] ren_sub;

  logic in_fire, out_free, cfg_wr;
  logic [asd_pkg::SC_BITS:0] sc_sum, fin_sum;
  logic found;

  // output register load
  logic               out_load;
  asd_pkg::out_beat_t out_next;

  assign pready   = 1'b1;
  assign prdata   = {{(32 - IB){1'b0}}, symbol_count};
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == asd_pkg::REG_SYMBOL_COUNT);

  assign in_stall = (state != asd_pkg::S_IDLE) || (out_valid && out_stall);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // symbol count clamps: zero acts as one, large acts as the alphabet size
  always_comb begin
    if (symbol_count == '0) begin
      n_act = IB'(1);
    end else if (symbol_count > IB'(asd_pkg::MAX_SYMBOLS)) begin
      n_act = IB'(asd_pkg::MAX_SYMBOLS);
    end else begin
      n_act = symbol_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_count <= IB'(asd_pkg::MAX_SYMBOLS);
    end else if (cfg_wr) begin
      symbol_count <= pwdata[IB-1:0];
    end
  end

  // one read port: total on decode start, then the search walks downward
  always_comb begin
    if (state == asd_pkg::S_SRD) begin
      raddr = sidx - IB'(1);
    end else begin
      raddr = n_act;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (in_data.opcode == asd_pkg::OP_LOAD) &&
        (in_data.table_index <= IB'(asd_pkg::MAX_SYMBOLS))) begin
      mem[in_data.table_index] <= in_data.table_value;
    end
    rdata <= mem[raddr];
  end

  // shared multiplier operand select
  always_comb begin
    case (ph)
      asd_pkg::PH_CUM: begin
        mul_a = cv1_r;
        mul_b = total_r;
      end
      asd_pkg::PH_HI: begin
        mul_a = range_r;
        mul_b = cs1_r;
      end
      default: begin
        mul_a = range_r;
        mul_b = cs_r;
      end
    endcase
  end

  // restoring divider step
  assign div_r2 = {rem, quo[PB-1]};
  assign div_ge = div_r2 >= {1'b0, dsr};

  // renorm case select: low half, high half, middle
  always_comb begin
    ren_go  = 1'b1;
    ren_sub = '0;
    if (hi_r < asd_pkg::HALF_POINT) begin
      ren_sub = '0;
    end else if (lo_r >= asd_pkg::HALF_POINT) begin
      ren_sub = asd_pkg::HALF_POINT;
    end else if (lo_r >= asd_pkg::Q1_POINT && hi_r < asd_pkg::Q3_POINT) begin
      ren_sub = asd_pkg::Q1_POINT;
    end else begin
      ren_go = 1'b0;
    end
    if (taken >= asd_pkg::USED_BITS'(asd_pkg::WINDOW_BITS)) begin
      ren_go = 1'b0;
    end
  end

  assign found   = ({{(PB - TB){1'b0}}, rdata} <= quo) || (sidx == IB'(1));
  assign sc_sum  = {1'b0, sc} + {{(asd_pkg::SC_BITS + 1 - asd_pkg::USED_BITS){1'b0}}, taken};
  assign fin_sum = {1'b0, sc} + (asd_pkg::SC_BITS + 1)'(2);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      asd_pkg::S_IDLE: begin
        if (in_fire && (in_data.opcode == asd_pkg::OP_DECODE)) begin
          state_next = asd_pkg::S_TOT;
        end
      end
      asd_pkg::S_TOT: begin
        state_next = (rdata == '0) ? asd_pkg::S_OUT : asd_pkg::S_MUL;
      end
      asd_pkg::S_MUL:  state_next = asd_pkg::S_LOAD;
      asd_pkg::S_LOAD: state_next = asd_pkg::S_DIV;
      asd_pkg::S_DIV: begin
        if (cnt == asd_pkg::CNT_BITS'(PB - 1)) begin
          state_next = asd_pkg::S_POST;
        end
      end
      asd_pkg::S_POST: begin
        case (ph)
          asd_pkg::PH_CUM: state_next = asd_pkg::S_SRD;
          asd_pkg::PH_HI:  state_next = asd_pkg::S_MUL;
          default:         state_next = asd_pkg::S_REN;
        endcase
      end
      asd_pkg::S_SRD:  state_next = asd_pkg::S_SCMP;
      asd_pkg::S_SCMP: state_next = found ? asd_pkg::S_MUL : asd_pkg::S_SRD;
      asd_pkg::S_REN: begin
        if (!ren_go) begin
          state_next = asd_pkg::S_OUT;
        end
      end
      asd_pkg::S_OUT: begin
        if (out_free) begin
          state_next = asd_pkg::S_IDLE;
        end
      end
      default: state_next = asd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= asd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // result beat for the output register; load/start/finish ops and decode end never overlap
  always_comb begin
    out_load = 1'b0;
    out_next = '0;
    if (in_fire) begin
      case (in_data.opcode)
        asd_pkg::OP_LOAD: begin
          out_load = 1'b1;
        end
        asd_pkg::OP_START: begin
          out_load = 1'b1;
          out_next.bits_consumed = asd_pkg::USED_BITS'(asd_pkg::WINDOW_BITS);
        end
        asd_pkg::OP_FINISH: begin
          out_load = 1'b1;
          out_next.total_bits = fin_sum[asd_pkg::SC_BITS] ? asd_pkg::SC_MAX
                                                          : fin_sum[asd_pkg::SC_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
    if (state == asd_pkg::S_OUT && out_free) begin
      out_load               = 1'b1;
      out_next.symbol        = sym_r;
      out_next.bits_consumed = taken;
    end
  end

  // session state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ilow      <= '0;
      ihigh     <= '1;
      code      <= '0;
      sc        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        out_data  <= out_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (in_fire && (in_data.opcode == asd_pkg::OP_START)) begin
        ilow  <= '0;
        ihigh <= '1;
        code  <= in_data.stream_bits;
        sc    <= '0;
      end
      if (state == asd_pkg::S_OUT && out_free) begin
        ilow  <= lo_r;
        ihigh <= hi_r;
        code  <= v_r;
        sc    <= sc_sum[asd_pkg::SC_BITS] ? asd_pkg::SC_MAX
                                          : sc_sum[asd_pkg::SC_BITS-1:0];
      end
    end
  end

  // decode datapath
  always_ff @(posedge clk) begin
    case (state)
      asd_pkg::S_IDLE: begin
        n_r   <= n_act;
        win_r <= in_data.stream_bits;
      end
      asd_pkg::S_TOT: begin
        // zero total leaves the state as it is
        sym_r   <= '0;
        taken   <= '0;
        lo_r    <= ilow;
        hi_r    <= ihigh;
        v_r     <= code;
        total_r <= rdata;
        prev_r  <= rdata;
        sidx    <= n_r;
        ph      <= asd_pkg::PH_CUM;
        range_r <= {1'b0, ihigh - ilow} + RB'(1);
        cv1_r   <= {1'b0, code - ilow} + RB'(1);
      end
      asd_pkg::S_MUL: begin
        prod <= PB'(mul_a * mul_b);
      end
      asd_pkg::S_LOAD: begin
        quo <= (ph == asd_pkg::PH_CUM) ? prod - PB'(1) : prod;
        dsr <= (ph == asd_pkg::PH_CUM) ? range_r : {{(RB - TB){1'b0}}, total_r};
        rem <= '0;
        cnt <= '0;
      end
      asd_pkg::S_DIV: begin
        rem <= div_ge ? RB'(div_r2 - {1'b0, dsr}) : div_r2[RB-1:0];
        quo <= {quo[PB-2:0], div_ge};
        cnt <= cnt + asd_pkg::CNT_BITS'(1);
      end
      asd_pkg::S_POST: begin
        case (ph)
          asd_pkg::PH_HI: begin
            hi_r <= ilow + quo[CB-1:0] - CB'(1);
            ph   <= asd_pkg::PH_LO;
          end
          asd_pkg::PH_LO: begin
            lo_r  <= ilow + quo[CB-1:0];
            v_r   <= code;
            taken <= '0;
          end
          default: begin
          end
        endcase
      end
      asd_pkg::S_SCMP: begin
        if (found) begin
          sym_r <= asd_pkg::SYM_BITS'(sidx - IB'(1));
          cs_r  <= rdata;
          cs1_r <= prev_r;
          ph    <= asd_pkg::PH_HI;
        end else begin
          prev_r <= rdata;
          sidx   <= sidx - IB'(1);
        end
      end
      asd_pkg::S_REN: begin
        if (ren_go) begin
          lo_r  <= (lo_r - ren_sub) << 1;
          hi_r  <= ((hi_r - ren_sub) << 1) | CB'(1);
          v_r   <= ((v_r - ren_sub) << 1) | CB'(win_r[CB-1]);
          win_r <= win_r << 1;
          taken <= taken + asd_pkg::USED_BITS'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // checks
  `ASD_ASSERT_IMP(a_busy_stalls, state != asd_pkg::S_IDLE, in_stall)
  `ASD_ASSERT_IMP(a_div_rem, state == asd_pkg::S_DIV, rem < dsr)
  `ASD_ASSERT_IMP(a_taken_max, state == asd_pkg::S_REN, taken <= asd_pkg::USED_BITS'(16))
  `ASD_ASSERT_NXT(a_out_done, state == asd_pkg::S_OUT && out_free, out_valid)
endmodule
